FILE: sv/cltok_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Shared codes, character constants and the result record type.
// ----------------------------------------------------------------------------
package cltok_pkg;

  localparam int KIND_W   = 2;
  localparam int DATA_W   = 8;
  localparam int POS_W    = 10;
  localparam int LEN_W    = 11;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int MAXTOK_W = 5;
  localparam int CAP_W    = 11;
  localparam int CFG_W    = 11;
  localparam int MODE_W   = 3;

  localparam logic [LEN_W-1:0] LEN_MAX = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_BETWEEN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BARE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_QUOTED  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd4;
  localparam logic [MODE_W-1:0] MODE_ERROR   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TOKEN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 2'd3;

  localparam logic REG_MAX_TOKENS       = 1'b0;
  localparam logic REG_SCRATCH_CAPACITY = 1'b1;

  localparam logic [DATA_W-1:0] CH_NUL    = 8'h00;
  localparam logic [DATA_W-1:0] CH_TAB    = 8'h09;
  localparam logic [DATA_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [DATA_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [DATA_W-1:0] CH_HASH   = 8'h23;
  localparam logic [DATA_W-1:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [DATA_W-1:0]   data_byte;
    logic [POS_W-1:0]    position;
    logic [LEN_W-1:0]    token_length;
    logic [IDX_W-1:0]    token_index;
    logic                quoted;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  token_count;
    logic                line_done;
  } result_t;

endpackage

FILE: sv/command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a zero-terminated command line into bare and quoted tokens.
// ----------------------------------------------------------------------------
// The line enters one byte per item on the input channel (in_valid, in_stall,
// char_code); a zero byte ends the line. Each accepted byte updates the scan
// state in the same cycle and pushes zero, one or two result items into a
// four-entry output queue. Results leave on the output channel (out_valid,
// out_stall and one port per field) in order, each read straight from the
// registered queue entry that holds it.
// The block takes one byte per cycle as long as results are taken; it only
// stalls its input when the queue holds more than two items, so a stalled
// receiver backs up into in_stall and nothing is lost.
// The registers max_tokens and scratch_capacity are written through the
// cfg_write, cfg_index and cfg_data port and take effect from the next byte.
// Reset empties the queue, returns the scan state to between tokens and sets
// max_tokens to 8 and scratch_capacity to 512.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit #(
  parameter int TOKEN_LIMIT   = 16,
  parameter int SCRATCH_BYTES = 1024,
  parameter int LINE_BYTES    = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cltok_pkg::DATA_W-1:0]     char_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cltok_pkg::KIND_W-1:0]     kind,
  output logic [cltok_pkg::DATA_W-1:0]     data_byte,
  output logic [cltok_pkg::POS_W-1:0]      position,
  output logic [cltok_pkg::LEN_W-1:0]      token_length,
  output logic [cltok_pkg::IDX_W-1:0]      token_index,
  output logic                             quoted,
  output logic [cltok_pkg::STATUS_W-1:0]   status,
  output logic [cltok_pkg::COUNT_W-1:0]    token_count,
  output logic                             line_done,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [cltok_pkg::CFG_W-1:0]      cfg_data
);
  import cltok_pkg::*;

  localparam int TW   = $clog2(TOKEN_LIMIT + 1);
  localparam int SW   = $clog2(SCRATCH_BYTES + 1);
  localparam int LW   = $clog2(LINE_BYTES);
  localparam int STW  = (LW > SW) ? LW : SW;
  localparam int LIMW = (TW > MAXTOK_W) ? TW : MAXTOK_W;
  localparam int CW   = ((SW > LEN_W) ? SW : LEN_W) + 1;
  localparam int QD   = 4;
  localparam int QPW  = 2;
  localparam int QCW  = 3;

  logic [MAXTOK_W-1:0] max_tokens;
  logic [CAP_W-1:0]    scratch_capacity;

  logic [MODE_W-1:0]   mode, mode_next;
  logic [LW-1:0]       line_position, line_position_next;
  logic [TW-1:0]       tokens_seen, tokens_seen_next;
  logic [SW-1:0]       scratch_used, scratch_used_next;
  logic [STW-1:0]      current_start, current_start_next;
  logic [LEN_W-1:0]    current_length, current_length_next;
  logic [STATUS_W-1:0] latched_error, latched_error_next;

  result_t             res [2];
  logic [1:0]          nres;
  logic                consumed;
  logic [LIMW-1:0]     lim;
  logic [CW-1:0]       cap;
  logic [CW-1:0]       left;
  logic [DATA_W-1:0]   qb;

  result_t             queue [QD];
  logic [QPW-1:0]      wr_ptr, rd_ptr;
  logic [QCW-1:0]      count;
  logic                accept, pop;
  logic [QCW-1:0]      push;

  function automatic result_t make_result(
    input logic [KIND_W-1:0]   k,
    input logic [DATA_W-1:0]   d,
    input logic [POS_W-1:0]    p,
    input logic [LEN_W-1:0]    l,
    input logic [IDX_W-1:0]    i,
    input logic                q,
    input logic [STATUS_W-1:0] s,
    input logic [COUNT_W-1:0]  n,
    input logic                e
  );
    result_t r;
    r.kind         = k;
    r.data_byte    = d;
    r.position     = p;
    r.token_length = l;
    r.token_index  = i;
    r.quoted       = q;
    r.status       = s;
    r.token_count  = n;
    r.line_done    = e;
    return r;
  endfunction

  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign in_stall = (count > QCW'(QD - 2));
  assign out_valid = (count != '0);

  always_comb begin
    mode_next           = mode;
    line_position_next  = line_position;
    tokens_seen_next    = tokens_seen;
    scratch_used_next   = scratch_used;
    current_start_next  = current_start;
    current_length_next = current_length;
    latched_error_next  = latched_error;
    res[0]   = '0;
    res[1]   = '0;
    nres     = 2'd0;
    consumed = 1'b0;
    qb       = CH_BSLASH;

    lim = (LIMW'(max_tokens) > LIMW'(TOKEN_LIMIT)) ? LIMW'(TOKEN_LIMIT) : LIMW'(max_tokens);
    cap = (CW'(scratch_capacity) > CW'(SCRATCH_BYTES)) ? CW'(SCRATCH_BYTES)
                                                        : CW'(scratch_capacity);
    left = (cap > CW'(scratch_used)) ? (cap - CW'(scratch_used)) : '0;

    if (mode == MODE_ESCAPE) begin
      if (char_code == CH_QUOTE || char_code == CH_BSLASH) begin
        qb       = char_code;
        consumed = 1'b1;
      end
      if (CW'(current_length_next) < left) begin
        res[nres[0]] = make_result(KIND_DATA, qb,
            POS_W'(CW'(scratch_used) + CW'(current_length_next)),
            '0, '0, 1'b0, ST_OK, '0, 1'b0);
        nres = nres + 2'd1;
      end
      if (current_length_next < LEN_MAX) begin
        current_length_next = current_length_next + LEN_W'(1);
      end
      mode_next = MODE_QUOTED;
    end

    if (char_code == CH_NUL) begin
      if (mode_next == MODE_BARE) begin
        res[nres[0]] = make_result(KIND_TOKEN, '0, POS_W'(current_start),
            current_length_next, IDX_W'(tokens_seen), 1'b0, ST_OK, '0, 1'b0);
        nres = nres + 2'd1;
        tokens_seen_next = tokens_seen + TW'(1);
      end else if (mode_next == MODE_QUOTED) begin
        if (latched_error_next == ST_OK) begin
          latched_error_next = ST_UNCLOSED;
        end
      end
      res[nres[0]] = make_result(KIND_SUMMARY, '0, '0, '0, '0, 1'b0, latched_error_next,
          (latched_error_next != ST_OK) ? '0 : COUNT_W'(tokens_seen_next), 1'b1);
      nres = nres + 2'd1;
      mode_next           = MODE_BETWEEN;
      line_position_next  = '0;
      tokens_seen_next    = '0;
      scratch_used_next   = '0;
      current_start_next  = '0;
      current_length_next = '0;
      latched_error_next  = ST_OK;
    end else begin
      if (!consumed) begin
        case (mode_next)
          MODE_BETWEEN: begin
            if (char_code == CH_SPACE || char_code == CH_TAB) begin
              mode_next = MODE_BETWEEN;
            end else if (char_code == CH_HASH) begin
              mode_next = MODE_COMMENT;
            end else if (LIMW'(tokens_seen) >= lim) begin
              if (latched_error_next == ST_OK) begin
                latched_error_next = ST_TOO_MANY;
              end
              mode_next = MODE_ERROR;
            end else if (char_code == CH_QUOTE) begin
              mode_next           = MODE_QUOTED;
              current_start_next  = STW'(scratch_used);
              current_length_next = '0;
            end else begin
              mode_next           = MODE_BARE;
              current_start_next  = STW'(line_position);
              current_length_next = LEN_W'(1);
            end
          end
          MODE_BARE: begin
            if (char_code == CH_SPACE || char_code == CH_TAB || char_code == CH_HASH) begin
              res[nres[0]] = make_result(KIND_TOKEN, '0, POS_W'(current_start),
                  current_length_next, IDX_W'(tokens_seen), 1'b0, ST_OK, '0, 1'b0);
              nres = nres + 2'd1;
              tokens_seen_next = tokens_seen + TW'(1);
              mode_next = (char_code == CH_HASH) ? MODE_COMMENT : MODE_BETWEEN;
            end else if (current_length_next < LEN_MAX) begin
              current_length_next = current_length_next + LEN_W'(1);
            end
          end
          MODE_QUOTED: begin
            if (char_code == CH_QUOTE) begin
              if (CW'(current_length_next) > left) begin
                if (latched_error_next == ST_OK) begin
                  latched_error_next = ST_TOO_LONG;
                end
                mode_next = MODE_ERROR;
              end else begin
                res[nres[0]] = make_result(KIND_TOKEN, '0, POS_W'(scratch_used),
                    current_length_next, IDX_W'(tokens_seen), 1'b1, ST_OK, '0, 1'b0);
                nres = nres + 2'd1;
                scratch_used_next = SW'(CW'(scratch_used) + CW'(current_length_next));
                tokens_seen_next  = tokens_seen + TW'(1);
                mode_next         = MODE_BETWEEN;
              end
            end else if (char_code == CH_BSLASH) begin
              mode_next = MODE_ESCAPE;
            end else begin
              if (CW'(current_length_next) < left) begin
                res[nres[0]] = make_result(KIND_DATA, char_code,
                    POS_W'(CW'(scratch_used) + CW'(current_length_next)),
                    '0, '0, 1'b0, ST_OK, '0, 1'b0);
                nres = nres + 2'd1;
              end
              if (current_length_next < LEN_MAX) begin
                current_length_next = current_length_next + LEN_W'(1);
              end
            end
          end
          default: begin
            mode_next = mode_next;
          end
        endcase
      end
      if (line_position < LW'(LINE_BYTES - 1)) begin
        line_position_next = line_position + LW'(1);
      end
    end
  end

  assign push = accept ? QCW'(nres) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tokens       <= MAXTOK_W'(8);
      scratch_capacity <= CAP_W'(512);
    end else if (cfg_write) begin
      if (cfg_index == REG_MAX_TOKENS) begin
        max_tokens <= cfg_data[MAXTOK_W-1:0];
      end else begin
        scratch_capacity <= cfg_data[CAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_BETWEEN;
      line_position  <= '0;
      tokens_seen    <= '0;
      scratch_used   <= '0;
      current_start  <= '0;
      current_length <= '0;
      latched_error  <= ST_OK;
    end else if (accept) begin
      mode           <= mode_next;
      line_position  <= line_position_next;
      tokens_seen    <= tokens_seen_next;
      scratch_used   <= scratch_used_next;
      current_start  <= current_start_next;
      current_length <= current_length_next;
      latched_error  <= latched_error_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) begin
      queue[wr_ptr] <= res[0];
    end
    if (accept && nres == 2'd2) begin
      queue[wr_ptr + QPW'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPW'(push);
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      count <= count + push - QCW'(pop);
    end
  end

  assign kind         = queue[rd_ptr].kind;
  assign data_byte    = queue[rd_ptr].data_byte;
  assign position     = queue[rd_ptr].position;
  assign token_length = queue[rd_ptr].token_length;
  assign token_index  = queue[rd_ptr].token_index;
  assign quoted       = queue[rd_ptr].quoted;
  assign status       = queue[rd_ptr].status;
  assign token_count  = queue[rd_ptr].token_count;
  assign line_done    = queue[rd_ptr].line_done;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QD))
    else $error("result queue overflow");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && char_code == CH_NUL) |=>
      (mode == MODE_BETWEEN && tokens_seen == '0 && latched_error == ST_OK))
    else $error("line end did not clear the scan state");

  a_error_holds: assert property (@(posedge clk) disable iff (rst)
    (latched_error != ST_OK && !(accept && char_code == CH_NUL)) |=>
      (latched_error == $past(latched_error) && mode == MODE_ERROR))
    else $error("latched error changed before line end");

endmodule

FILE: tb/command_line_tokenizer_scoreboard.sv
// ----------------------------------------------------------------------------
// Command line tokenizer scoreboard
// Watches the byte, result and register ports of the tokenizer, keeps its own
// copy of the scan state and registers, predicts the result items of every
// accepted byte and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module command_line_tokenizer_scoreboard
  import cltok_pkg::*;
#(
  parameter int TOKEN_LIMIT   = 16,
  parameter int SCRATCH_BYTES = 1024,
  parameter int LINE_BYTES    = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [DATA_W-1:0]   char_code,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [KIND_W-1:0]   kind,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic [POS_W-1:0]    position,
  input  logic [LEN_W-1:0]    token_length,
  input  logic [IDX_W-1:0]    token_index,
  input  logic                quoted,
  input  logic [STATUS_W-1:0] status,
  input  logic [COUNT_W-1:0]  token_count,
  input  logic                line_done,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output int                  mismatch_count,
  output int                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MAXTOK_W-1:0] reg_max_tokens;
  logic [CAP_W-1:0]    reg_capacity;

  logic [MODE_W-1:0]   scan_state;
  logic [POS_W-1:0]    line_offset;
  logic [COUNT_W-1:0]  token_total;
  logic [CAP_W-1:0]    scratch_fill;
  logic [POS_W-1:0]    token_start;
  logic [LEN_W-1:0]    token_bytes;
  logic [STATUS_W-1:0] first_error;

  result_t predicted_records[$];
  int      errors = 0;

  function automatic logic [CAP_W-1:0] scratch_room();
    logic [CAP_W-1:0] cap;
    cap = (reg_capacity > SCRATCH_BYTES) ? CAP_W'(SCRATCH_BYTES) : reg_capacity;
    return (cap > scratch_fill) ? cap - scratch_fill : '0;
  endfunction

  task automatic reset_line_state();
    scan_state   = MODE_BETWEEN;
    line_offset  = '0;
    token_total  = '0;
    scratch_fill = '0;
    token_start  = '0;
    token_bytes  = '0;
    first_error  = ST_OK;
  endtask

  task automatic latch_error(input logic [STATUS_W-1:0] code);
    if (first_error == ST_OK) begin
      first_error = code;
    end
    scan_state = MODE_ERROR;
  endtask

  task automatic close_bare();
    predicted_records.push_back({KIND_TOKEN, 8'd0, token_start, token_bytes,
                                 token_total[IDX_W-1:0], 1'b0, ST_OK, 5'd0, 1'b0});
    token_total++;
  endtask

  // Bytes past the remaining scratch space are counted but not written.
  task automatic store_quoted(input logic [DATA_W-1:0] c);
    logic [CAP_W-1:0] addr;
    if (token_bytes < scratch_room()) begin
      addr = scratch_fill + token_bytes;
      predicted_records.push_back({KIND_DATA, c, addr[POS_W-1:0], 11'd0, 4'd0, 1'b0,
                                   ST_OK, 5'd0, 1'b0});
    end
    if (token_bytes != LEN_MAX) begin
      token_bytes++;
    end
  endtask

  task automatic finish_line();
    if (scan_state == MODE_BARE) begin
      close_bare();
    end else if (scan_state == MODE_QUOTED) begin
      latch_error(ST_UNCLOSED);
    end
    predicted_records.push_back({KIND_SUMMARY, 8'd0, 10'd0, 11'd0, 4'd0, 1'b0, first_error,
                                 (first_error == ST_OK) ? token_total : 5'd0, 1'b1});
    reset_line_state();
  endtask

  task automatic tokenize_byte(input logic [DATA_W-1:0] c);
    logic consumed;
    int   lim;
    consumed = 1'b0;
    lim = (reg_max_tokens > TOKEN_LIMIT) ? TOKEN_LIMIT : int'(reg_max_tokens);
    if (scan_state == MODE_ESCAPE) begin
      consumed = (c == CH_QUOTE || c == CH_BSLASH);
      store_quoted(consumed ? c : CH_BSLASH);
      scan_state = MODE_QUOTED;
    end
    if (!consumed && c == CH_NUL) begin
      finish_line();
    end else begin
      if (!consumed) begin
        case (scan_state)
          MODE_BETWEEN: begin
            if (c == CH_HASH) begin
              scan_state = MODE_COMMENT;
            end else if (c != CH_SPACE && c != CH_TAB) begin
              if (token_total >= lim) begin
                latch_error(ST_TOO_MANY);
              end else if (c == CH_QUOTE) begin
                scan_state  = MODE_QUOTED;
                token_bytes = '0;
              end else begin
                scan_state  = MODE_BARE;
                token_start = line_offset;
                token_bytes = 11'd1;
              end
            end
          end
          MODE_BARE: begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_HASH) begin
              close_bare();
              scan_state = (c == CH_HASH) ? MODE_COMMENT : MODE_BETWEEN;
            end else if (token_bytes != LEN_MAX) begin
              token_bytes++;
            end
          end
          MODE_QUOTED: begin
            if (c == CH_QUOTE) begin
              if (token_bytes > scratch_room()) begin
                latch_error(ST_TOO_LONG);
              end else begin
                predicted_records.push_back({KIND_TOKEN, 8'd0, scratch_fill[POS_W-1:0],
                                             token_bytes, token_total[IDX_W-1:0], 1'b1,
                                             ST_OK, 5'd0, 1'b0});
                scratch_fill += token_bytes;
                token_total++;
                scan_state = MODE_BETWEEN;
              end
            end else if (c == CH_BSLASH) begin
              scan_state = MODE_ESCAPE;
            end else begin
              store_quoted(c);
            end
          end
          default: begin
          end
        endcase
      end
      if (line_offset < LINE_BYTES - 1) begin
        line_offset++;
      end
    end
  endtask

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    if (rst) begin
      reg_max_tokens = 5'd8;
      reg_capacity   = 11'd512;
      reset_line_state();
      predicted_records.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_MAX_TOKENS) begin
          reg_max_tokens = cfg_data[MAXTOK_W-1:0];
        end else begin
          reg_capacity = cfg_data[CAP_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        tokenize_byte(char_code);
      end
      if (out_valid && !out_stall) begin
        got = {kind, data_byte, position, token_length, token_index, quoted, status,
               token_count, line_done};
        if (predicted_records.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: unexpected result kind=%0d data=%02h pos=%0d len=%0d idx=%0d",
                     $realtime, got.kind, got.data_byte, got.position, got.token_length,
                     got.token_index);
          end
        end else begin
          want = predicted_records.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.position !== want.position || got.token_length !== want.token_length ||
              got.token_index !== want.token_index || got.quoted !== want.quoted ||
              got.status !== want.status || got.token_count !== want.token_count ||
              got.line_done !== want.line_done) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected kind=%0d data=%02h pos=%0d len=%0d idx=%0d q=%0d st=%0d cnt=%0d done=%0d",
                       $realtime, want.kind, want.data_byte, want.position,
                       want.token_length, want.token_index, want.quoted, want.status,
                       want.token_count, want.line_done);
              $display("%0t: mismatch actual   kind=%0d data=%02h pos=%0d len=%0d idx=%0d q=%0d st=%0d cnt=%0d done=%0d",
                       $realtime, got.kind, got.data_byte, got.position, got.token_length,
                       got.token_index, got.quoted, got.status, got.token_count,
                       got.line_done);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    outstanding    <= predicted_records.size();
  end

endmodule

FILE: tb/command_line_tokenizer_unit_test.sv
// ----------------------------------------------------------------------------
// Command line tokenizer testbench
// Feeds directed and random command lines, bare and quoted tokens, escapes,
// comments, unclosed quotes and noise, under several register settings and
// with random gaps and stalls on both channels; a scoreboard checks results.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cltok_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [DATA_W-1:0]   char_code = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [DATA_W-1:0]   data_byte;
  logic [POS_W-1:0]    position;
  logic [LEN_W-1:0]    token_length;
  logic [IDX_W-1:0]    token_index;
  logic                quoted;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  token_count;
  logic                line_done;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_MAX_TOKENS;
  logic [CFG_W-1:0]    cfg_data = '0;
  int                  mismatches;
  int                  outstanding;

  logic [DATA_W-1:0] line_bytes[$];
  int                tx_idle_max = 17;
  int                sent_count = 0;

  always #5 clk = ~clk;

  command_line_tokenizer_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .data_byte(data_byte), .position(position),
    .token_length(token_length), .token_index(token_index), .quoted(quoted),
    .status(status), .token_count(token_count), .line_done(line_done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  command_line_tokenizer_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .data_byte(data_byte), .position(position),
    .token_length(token_length), .token_index(token_index), .quoted(quoted),
    .status(status), .token_count(token_count), .line_done(line_done),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatches), .outstanding(outstanding)
  );

  function automatic logic [DATA_W-1:0] pick_bare_char();
    logic [DATA_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = CH_QUOTE;
      1: c = CH_BSLASH;
      2, 3: c = 8'($urandom_range(1, 255));
      default: c = 8'($urandom_range(8'h61, 8'h7a));
    endcase
    if (c == CH_SPACE || c == CH_TAB || c == CH_HASH) begin
      c = 8'h5f;
    end
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] pick_text_char();
    logic [DATA_W-1:0] c;
    c = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
                                     : 8'($urandom_range(8'h20, 8'h7e));
    if (c == CH_QUOTE || c == CH_BSLASH) begin
      c = 8'h78;
    end
    return c;
  endfunction

  function automatic int quoted_size();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 8);
  endfunction

  task automatic add_gap();
    repeat ($urandom_range(1, 3)) begin
      line_bytes.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB);
    end
  endtask

  task automatic add_bare(input int len);
    logic [DATA_W-1:0] c;
    c = pick_bare_char();
    line_bytes.push_back((c == CH_QUOTE) ? 8'h61 : c);
    repeat (len - 1) begin
      line_bytes.push_back(pick_bare_char());
    end
  endtask

  task automatic add_quoted(input int len, input bit closed);
    line_bytes.push_back(CH_QUOTE);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0: begin
          line_bytes.push_back(CH_BSLASH);
          line_bytes.push_back(CH_QUOTE);
        end
        1: begin
          line_bytes.push_back(CH_BSLASH);
          line_bytes.push_back(CH_BSLASH);
        end
        2: begin
          line_bytes.push_back(CH_BSLASH);
          line_bytes.push_back(pick_text_char());
        end
        default: line_bytes.push_back(pick_text_char());
      endcase
    end
    if (closed) begin
      line_bytes.push_back(CH_QUOTE);
    end else if ($urandom_range(0, 1) != 0) begin
      line_bytes.push_back(CH_BSLASH);
    end
  endtask

  task automatic send_byte(input logic [DATA_W-1:0] c);
    int gap;
    gap = $urandom_range(tx_idle_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) begin
      send_byte(line_bytes[i]);
    end
    send_byte(CH_NUL);
    sent_count += line_bytes.size() + 1;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [MAXTOK_W-1:0] max_tok,
                              input logic [CAP_W-1:0] cap);
    cfg_write <= 1'b1;
    cfg_index <= REG_MAX_TOKENS;
    cfg_data  <= {6'($urandom), max_tok};
    @(posedge clk);
    cfg_index <= REG_SCRATCH_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin : receiver
    int gap;
    int taken;
    int rx_idle_max;
    bit held;
    taken = 0;
    rx_idle_max = 17;
    held = 1'b0;
    forever begin
      if (!held && taken >= 60 && in_valid) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      if (taken % 40 == 0) begin
        rx_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
      end
      gap = $urandom_range(rx_idle_max, 0);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int phase_no;
    int ntok;
    int ending;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    line_bytes.delete();
    send_line();
    line_bytes = '{8'h61, 8'h62, CH_SPACE, CH_QUOTE, 8'h71, CH_BSLASH, CH_QUOTE,
                   CH_BSLASH, CH_BSLASH, CH_BSLASH, 8'h7a, CH_QUOTE, CH_SPACE, CH_HASH,
                   8'h63};
    send_line();
    line_bytes = '{8'hff, 8'h77, CH_HASH, 8'h79};
    send_line();
    line_bytes = '{CH_TAB, CH_QUOTE, 8'h61, CH_BSLASH};
    send_line();

    sent_count = 0;
    phase_no = 0;
    while (phase_no < 6 || sent_count < 450) begin
      phase_no++;
      wait_idle();
      case (phase_no)
        1: program_regs(5'd0, 11'd0);
        2: program_regs(5'd1, 11'd3);
        3: program_regs(5'd16, 11'd1024);
        4: program_regs(5'd31, 11'd2047);
        default: program_regs(5'($urandom_range(0, 31)),
                              ($urandom_range(0, 1) != 0) ? 11'($urandom_range(0, 64))
                                                          : 11'($urandom_range(0, 2047)));
      endcase
      repeat (2) begin
        tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
        line_bytes.delete();
        ntok = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 18) : $urandom_range(0, 6);
        ending = $urandom_range(0, 19);
        if (ending == 0) begin
          repeat ($urandom_range(1, 20)) begin
            line_bytes.push_back(8'($urandom_range(0, 255)));
          end
        end else begin
          if ($urandom_range(0, 3) == 0) begin
            add_gap();
          end
          for (int i = 0; i < ntok; i++) begin
            if (i > 0) begin
              add_gap();
            end
            if ($urandom_range(0, 2) == 0) begin
              add_quoted(quoted_size(), 1'b1);
            end else begin
              add_bare($urandom_range(1, 6));
            end
          end
          case (ending)
            1, 2: begin
              if ($urandom_range(0, 1) != 0) begin
                add_gap();
              end
              line_bytes.push_back(CH_HASH);
              repeat ($urandom_range(0, 6)) begin
                line_bytes.push_back(8'($urandom_range(1, 255)));
              end
            end
            3, 4: begin
              if (ntok > 0) begin
                add_gap();
              end
              add_quoted(quoted_size(), 1'b0);
            end
            default: begin
              if ($urandom_range(0, 2) == 0) begin
                add_gap();
              end
            end
          endcase
        end
        send_line();
      end
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
